/* rtl/spg_pkg.sv */
// Shared constants, types and the control store of the staircase pattern generator.
package spg_pkg;

   localparam int LEN_BITS = 16;
   localparam int MAX_DIMS = 4;
   localparam int NUM_AXES = 4;

   localparam int DIMS_W  = 3;
   localparam int STEP_W  = 16;
   localparam int VAL_W   = 32;
   localparam int CSR_W   = 32;
   localparam int IDX_W   = 3;
   localparam int SUM_W   = LEN_BITS + 2;
   localparam int PHASE_W = STEP_W + 2;
   localparam int DVS_W   = STEP_W + 2;
   localparam int QUO_W   = VAL_W + 1;
   localparam int DVD_W   = (SUM_W > QUO_W) ? SUM_W : QUO_W;
   localparam int ITER_W  = $clog2(DVD_W + 1);
   localparam int GRAD_W  = QUO_W + 1;
   localparam int PROD_W  = GRAD_W + PHASE_W + 1;
   localparam int ACC_W   = PROD_W + 1;
   localparam int PC_W    = 4;

   typedef enum logic [IDX_W-1:0] {
      REG_NUM_DIMS,
      REG_SIZE_X,
      REG_SIZE_Y,
      REG_SIZE_Z,
      REG_SIZE_W,
      REG_MIN_VALUE,
      REG_MAX_VALUE,
      REG_STEP_SIZE
   } reg_idx_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_ACCEPT,
      ACT_CLEAR,
      ACT_START_GDIV,
      ACT_LOAD_GRAD,
      ACT_SUM,
      ACT_START_MOD,
      ACT_MULT,
      ACT_ADVANCE,
      ACT_SET_BAD,
      ACT_EMIT
   } act_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_NOT_RESTART,
      COND_BAD,
      COND_DIV_BUSY,
      COND_OUT_FREE
   } cond_type;

   typedef struct packed {
      act_type          act;
      cond_type         cond;
      logic [PC_W-1:0]  target;
   } ctl_type;

   typedef struct packed {
      logic req_valid;
      logic restart;
      logic bad;
      logic div_busy;
      logic out_free;
   } status_type;

   localparam logic [PC_W-1:0] STEP_WAIT      = PC_W'(0);
   localparam logic [PC_W-1:0] STEP_CHECK_RST = PC_W'(1);
   localparam logic [PC_W-1:0] STEP_CLEAR     = PC_W'(2);
   localparam logic [PC_W-1:0] STEP_GDIV      = PC_W'(3);
   localparam logic [PC_W-1:0] STEP_GDIV_WAIT = PC_W'(4);
   localparam logic [PC_W-1:0] STEP_LOAD_GRAD = PC_W'(5);
   localparam logic [PC_W-1:0] STEP_SUM       = PC_W'(6);
   localparam logic [PC_W-1:0] STEP_MOD       = PC_W'(7);
   localparam logic [PC_W-1:0] STEP_MOD_WAIT  = PC_W'(8);
   localparam logic [PC_W-1:0] STEP_MULT      = PC_W'(9);
   localparam logic [PC_W-1:0] STEP_ADVANCE   = PC_W'(10);
   localparam logic [PC_W-1:0] STEP_BAD       = PC_W'(11);
   localparam logic [PC_W-1:0] STEP_EMIT      = PC_W'(12);
   localparam logic [PC_W-1:0] STEP_EMIT_HOLD = PC_W'(13);

   // Control store: action, jump condition, jump target; falls through to pc+1.
   function automatic ctl_type rom_word(input logic [PC_W-1:0] pc);
      ctl_type w;
      w = '{act: ACT_NONE, cond: COND_ALWAYS, target: STEP_WAIT};
      unique case (pc)
         STEP_WAIT:      w = '{ACT_ACCEPT,     COND_NO_REQ,      STEP_WAIT};
         STEP_CHECK_RST: w = '{ACT_NONE,       COND_NOT_RESTART, STEP_SUM};
         STEP_CLEAR:     w = '{ACT_CLEAR,      COND_BAD,         STEP_BAD};
         STEP_GDIV:      w = '{ACT_START_GDIV, COND_NEVER,       STEP_WAIT};
         STEP_GDIV_WAIT: w = '{ACT_NONE,       COND_DIV_BUSY,    STEP_GDIV_WAIT};
         STEP_LOAD_GRAD: w = '{ACT_LOAD_GRAD,  COND_NEVER,       STEP_WAIT};
         STEP_SUM:       w = '{ACT_SUM,        COND_BAD,         STEP_BAD};
         STEP_MOD:       w = '{ACT_START_MOD,  COND_NEVER,       STEP_WAIT};
         STEP_MOD_WAIT:  w = '{ACT_NONE,       COND_DIV_BUSY,    STEP_MOD_WAIT};
         STEP_MULT:      w = '{ACT_MULT,       COND_NEVER,       STEP_WAIT};
         STEP_ADVANCE:   w = '{ACT_ADVANCE,    COND_ALWAYS,      STEP_EMIT};
         STEP_BAD:       w = '{ACT_SET_BAD,    COND_NEVER,       STEP_WAIT};
         STEP_EMIT:      w = '{ACT_EMIT,       COND_OUT_FREE,    STEP_WAIT};
         STEP_EMIT_HOLD: w = '{ACT_NONE,       COND_ALWAYS,      STEP_EMIT};
         default:        w = '{ACT_NONE,       COND_ALWAYS,      STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage

/* rtl/spg_div.sv */
// Shared restoring divider, one quotient bit per cycle.
module spg_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [spg_pkg::DVD_W-1:0]     dividend,
   input  logic [spg_pkg::DVS_W-1:0]     divisor,
   input  logic [spg_pkg::ITER_W-1:0]    iters,
   output logic                          busy,
   output logic [spg_pkg::DVD_W-1:0]     quotient,
   output logic [spg_pkg::DVS_W-1:0]     remainder
);

   logic [spg_pkg::DVD_W-1:0]  qr_ff;
   logic [spg_pkg::DVS_W-1:0]  rem_ff;
   logic [spg_pkg::DVS_W-1:0]  dvs_ff;
   logic [spg_pkg::ITER_W-1:0] cnt_ff;
   logic                       busy_ff;

   logic [spg_pkg::DVS_W:0]    shifted;
   logic [spg_pkg::DVS_W+1:0]  trial;
   logic [spg_pkg::DVS_W-1:0]  rem_in;
   logic                       qbit;

   // Dividend is left aligned; after n steps the quotient sits in the low n bits.
   always_comb begin
      shifted = {rem_ff, qr_ff[spg_pkg::DVD_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
      qbit    = ~trial[spg_pkg::DVS_W+1];
      rem_in  = qbit ? trial[spg_pkg::DVS_W-1:0] : shifted[spg_pkg::DVS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= iters;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - spg_pkg::ITER_W'(1);
         if (cnt_ff == spg_pkg::ITER_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         qr_ff  <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         qr_ff  <= {qr_ff[spg_pkg::DVD_W-2:0], qbit};
         rem_ff <= rem_in;
      end
   end

   assign busy      = busy_ff;
   assign quotient  = qr_ff;
   assign remainder = rem_ff;

   a_no_restart_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> $past(cnt_ff) == spg_pkg::ITER_W'(1))
      else $error("divider finished early");

endmodule

/* rtl/spg_seq.sv */
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module spg_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  spg_pkg::status_type  status,
   output spg_pkg::ctl_type     ctl
);

   logic [spg_pkg::PC_W-1:0] pc_ff;
   logic [spg_pkg::PC_W-1:0] pc_in;
   spg_pkg::ctl_type         word;
   logic                     taken;

   always_comb begin
      word = spg_pkg::rom_word(pc_ff);
      unique case (word.cond)
         spg_pkg::COND_NEVER:       taken = 1'b0;
         spg_pkg::COND_ALWAYS:      taken = 1'b1;
         spg_pkg::COND_NO_REQ:      taken = !status.req_valid;
         spg_pkg::COND_NOT_RESTART: taken = !status.restart;
         spg_pkg::COND_BAD:         taken = status.bad;
         spg_pkg::COND_DIV_BUSY:    taken = status.div_busy;
         spg_pkg::COND_OUT_FREE:    taken = status.out_free;
         default:                   taken = 1'b1;
      endcase
      pc_in = taken ? word.target : pc_ff + spg_pkg::PC_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= spg_pkg::STEP_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctl = word;

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == spg_pkg::STEP_WAIT && !status.req_valid) |=> pc_ff == spg_pkg::STEP_WAIT)
      else $error("sequencer left idle without a request");

endmodule

/* rtl/staircase_pattern_generator.sv */
// Staircase pattern generator top level: config registers, datapath, result register.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------------
//  req     | in        | req_valid/req_stall | req_restart
//  rsp     | out       | rsp_valid/rsp_stall | rsp_sample_value, rsp_last_element,
//          |           |                     | rsp_bad_setting
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata (ready always high)
//
// Flow: an element runs from request transfer through the position sum, the ramp-phase
//   division on the shared bit-serial divider, the multiply and the advance to the result.
//   A restart first adds the gradient division on the same divider.
//   With bad settings an element skips both divisions and is emitted with the bad flag.
// Reset: synchronous, active high; sequencer idles, positions and gradient clear,
//   config registers load their defaults.
// Stalls: the result register holds one element; the next request is taken while it
//   waits, and the sequencer parks at the emit step until the register frees.
module staircase_pattern_generator (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_restart,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [spg_pkg::VAL_W-1:0]  rsp_sample_value,
   output logic                              rsp_last_element,
   output logic                              rsp_bad_setting,
   // config write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [spg_pkg::IDX_W-1:0]         csr_index,
   input  logic [spg_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int LB = spg_pkg::LEN_BITS;

   // ---------------- configuration registers ----------------
   logic [spg_pkg::DIMS_W-1:0]        num_dims_ff;
   logic [LB-1:0]                     size_x_ff, size_y_ff, size_z_ff, size_w_ff;
   logic signed [spg_pkg::VAL_W-1:0]  min_ff, max_ff;
   logic [spg_pkg::STEP_W-1:0]        step_ff;

   // ---------------- datapath state ----------------
   logic [LB-1:0]                     pos_ff [spg_pkg::NUM_AXES];
   logic [LB-1:0]                     pos_in [spg_pkg::NUM_AXES];
   logic signed [spg_pkg::GRAD_W-1:0] grad_ff, grad_in;
   logic                              restart_ff;
   logic [spg_pkg::SUM_W-1:0]         sum_ff, sum_in;
   logic                              last_ff, last_in;
   logic signed [spg_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [spg_pkg::VAL_W-1:0]  val_ff, val_in;
   logic                              flag_ff;

   // result register
   logic                              rsp_valid_ff;
   logic signed [spg_pkg::VAL_W-1:0]  rsp_value_ff;
   logic                              rsp_last_ff;
   logic                              rsp_bad_ff;

   // ---------------- control ----------------
   spg_pkg::ctl_type                  ctl;
   spg_pkg::status_type               status;

   logic                              req_xfer;
   logic                              out_free;

   // divider hookup
   logic                              div_start;
   logic                              div_busy;
   logic [spg_pkg::DVD_W-1:0]         div_dividend;
   logic [spg_pkg::DVS_W-1:0]         div_divisor;
   logic [spg_pkg::ITER_W-1:0]        div_iters;
   logic [spg_pkg::DVD_W-1:0]         div_quo;
   logic [spg_pkg::DVS_W-1:0]         div_rem;

   // derived config values
   logic [spg_pkg::DIMS_W-1:0]        dims_eff;
   logic [LB-1:0]                     size_eff [spg_pkg::NUM_AXES];
   logic                              used [spg_pkg::NUM_AXES];
   logic                              bad;
   logic signed [spg_pkg::VAL_W:0]    diff;
   logic                              diff_neg;
   logic [spg_pkg::VAL_W:0]           diff_abs;
   logic [spg_pkg::DVS_W-1:0]         grad_div;
   logic [spg_pkg::DVS_W-1:0]         modulus;
   logic [spg_pkg::QUO_W-1:0]         grad_num;
   logic [spg_pkg::QUO_W-1:0]         quo;
   logic signed [spg_pkg::PHASE_W:0]  phase_s;
   logic [spg_pkg::ACC_W-1:0]         acc;
   logic                              acc_fits;
   logic                              carry;
   logic [LB:0]                       pos_inc;

   assign csr_ready = 1'b1;
   assign req_stall = (ctl.act != spg_pkg::ACT_ACCEPT);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Config writes; index decode covers every code of the 3-bit index.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff <= spg_pkg::DIMS_W'(1);
         size_x_ff   <= LB'(1);
         size_y_ff   <= LB'(1);
         size_z_ff   <= LB'(1);
         size_w_ff   <= LB'(1);
         min_ff      <= '0;
         max_ff      <= spg_pkg::VAL_W'(65536);
         step_ff     <= spg_pkg::STEP_W'(2);
      end else if (csr_valid && csr_ready) begin
         unique case (spg_pkg::reg_idx_type'(csr_index))
            spg_pkg::REG_NUM_DIMS:  num_dims_ff <= csr_wdata[spg_pkg::DIMS_W-1:0];
            spg_pkg::REG_SIZE_X:    size_x_ff   <= csr_wdata[LB-1:0];
            spg_pkg::REG_SIZE_Y:    size_y_ff   <= csr_wdata[LB-1:0];
            spg_pkg::REG_SIZE_Z:    size_z_ff   <= csr_wdata[LB-1:0];
            spg_pkg::REG_SIZE_W:    size_w_ff   <= csr_wdata[LB-1:0];
            spg_pkg::REG_MIN_VALUE: min_ff      <= csr_wdata[spg_pkg::VAL_W-1:0];
            spg_pkg::REG_MAX_VALUE: max_ff      <= csr_wdata[spg_pkg::VAL_W-1:0];
            spg_pkg::REG_STEP_SIZE: step_ff     <= csr_wdata[spg_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective settings: dimension count clamped, zero extents act as one.
   always_comb begin
      dims_eff = num_dims_ff;
      if (num_dims_ff == '0) begin
         dims_eff = spg_pkg::DIMS_W'(1);
      end else if (num_dims_ff > spg_pkg::DIMS_W'(spg_pkg::MAX_DIMS)) begin
         dims_eff = spg_pkg::DIMS_W'(spg_pkg::MAX_DIMS);
      end
      size_eff[0] = (size_x_ff == '0) ? LB'(1) : size_x_ff;
      size_eff[1] = (size_y_ff == '0) ? LB'(1) : size_y_ff;
      size_eff[2] = (size_z_ff == '0) ? LB'(1) : size_z_ff;
      size_eff[3] = (size_w_ff == '0) ? LB'(1) : size_w_ff;
      for (int i = 0; i < spg_pkg::NUM_AXES; i++) begin
         used[i] = (spg_pkg::DIMS_W'(i) < dims_eff);
      end
      bad = (step_ff < spg_pkg::STEP_W'(2)) || (min_ff == max_ff);
   end

   // Gradient operands: |max-min| + divisor/2, over D*(step-1), rounds half away.
   always_comb begin
      diff     = {max_ff[spg_pkg::VAL_W-1], max_ff} - {min_ff[spg_pkg::VAL_W-1], min_ff};
      diff_neg = diff[spg_pkg::VAL_W];
      diff_abs = diff_neg ? -diff : diff;
      grad_div = spg_pkg::DVS_W'(dims_eff)
               * spg_pkg::DVS_W'(step_ff - spg_pkg::STEP_W'(1));
      modulus  = spg_pkg::DVS_W'(dims_eff) * spg_pkg::DVS_W'(step_ff);
      grad_num = spg_pkg::QUO_W'(diff_abs[spg_pkg::VAL_W-1:0])
               + spg_pkg::QUO_W'(grad_div >> 1);
      quo      = div_quo[spg_pkg::QUO_W-1:0];
      grad_in  = diff_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
   end

   // Divider is shared: gradient on restart, then ramp phase = sum mod D*step.
   always_comb begin
      div_start = (ctl.act == spg_pkg::ACT_START_GDIV) || (ctl.act == spg_pkg::ACT_START_MOD);
      if (ctl.act == spg_pkg::ACT_START_GDIV) begin
         div_dividend = spg_pkg::DVD_W'(grad_num) << (spg_pkg::DVD_W - spg_pkg::QUO_W);
         div_divisor  = grad_div;
         div_iters    = spg_pkg::ITER_W'(spg_pkg::QUO_W);
      end else begin
         div_dividend = spg_pkg::DVD_W'(sum_ff) << (spg_pkg::DVD_W - spg_pkg::SUM_W);
         div_divisor  = modulus;
         div_iters    = spg_pkg::ITER_W'(spg_pkg::SUM_W);
      end
   end

   // Position sum, last-element test and raster advance (x fastest).
   always_comb begin
      sum_in  = '0;
      last_in = 1'b1;
      carry   = 1'b1;
      pos_inc = '0;
      for (int i = 0; i < spg_pkg::NUM_AXES; i++) begin
         pos_inc = {1'b0, pos_ff[i]} + (LB+1)'(1);
         pos_in[i] = '0;
         if (used[i]) begin
            sum_in = sum_in + spg_pkg::SUM_W'(pos_ff[i]);
            if (pos_inc < {1'b0, size_eff[i]}) begin
               last_in = 1'b0;
            end
            if (!carry) begin
               pos_in[i] = pos_ff[i];
            end else if (pos_inc >= {1'b0, size_eff[i]}) begin
               pos_in[i] = '0;
            end else begin
               pos_in[i] = pos_inc[LB-1:0];
               carry     = 1'b0;
            end
         end
      end
   end

   // Value = min + g*phase, formed exactly and clamped to the 32-bit range.
   always_comb begin
      phase_s  = $signed({1'b0, div_rem});
      prod_in  = grad_ff * phase_s;
      acc      = {{(spg_pkg::ACC_W-spg_pkg::VAL_W){min_ff[spg_pkg::VAL_W-1]}}, min_ff}
               + {prod_ff[spg_pkg::PROD_W-1], prod_ff};
      acc_fits = (acc[spg_pkg::ACC_W-1:spg_pkg::VAL_W-1]
                 == {(spg_pkg::ACC_W-spg_pkg::VAL_W+1){acc[spg_pkg::ACC_W-1]}});
      if (acc_fits) begin
         val_in = acc[spg_pkg::VAL_W-1:0];
      end else if (acc[spg_pkg::ACC_W-1]) begin
         val_in = {1'b1, {(spg_pkg::VAL_W-1){1'b0}}};
      end else begin
         val_in = {1'b0, {(spg_pkg::VAL_W-1){1'b1}}};
      end
   end

   // Architectural state: positions and gradient.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < spg_pkg::NUM_AXES; i++) begin
            pos_ff[i] <= '0;
         end
         grad_ff    <= '0;
         restart_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            restart_ff <= req_restart;
         end
         if (ctl.act == spg_pkg::ACT_CLEAR) begin
            for (int i = 0; i < spg_pkg::NUM_AXES; i++) begin
               pos_ff[i] <= '0;
            end
            grad_ff <= '0;
         end
         if (ctl.act == spg_pkg::ACT_LOAD_GRAD) begin
            grad_ff <= grad_in;
         end
         if (ctl.act == spg_pkg::ACT_ADVANCE) begin
            pos_ff <= pos_in;
         end
      end
   end

   // Working registers along the per-element path.
   always_ff @(posedge clock) begin
      if (ctl.act == spg_pkg::ACT_SUM) begin
         sum_ff  <= sum_in;
         last_ff <= last_in;
      end
      if (ctl.act == spg_pkg::ACT_MULT) begin
         prod_ff <= prod_in;
      end
      if (ctl.act == spg_pkg::ACT_ADVANCE) begin
         val_ff  <= val_in;
         flag_ff <= 1'b0;
      end
      if (ctl.act == spg_pkg::ACT_SET_BAD) begin
         val_ff  <= '0;
         last_ff <= 1'b0;
         flag_ff <= 1'b1;
      end
   end

   // Result register: one element, loaded at the emit step when free.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.act == spg_pkg::ACT_EMIT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.act == spg_pkg::ACT_EMIT && out_free) begin
         rsp_value_ff <= val_ff;
         rsp_last_ff  <= last_ff;
         rsp_bad_ff   <= flag_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_value = rsp_value_ff;
   assign rsp_last_element = rsp_last_ff;
   assign rsp_bad_setting  = rsp_bad_ff;

   assign status = '{
      req_valid: req_valid,
      restart:   restart_ff,
      bad:       bad,
      div_busy:  div_busy,
      out_free:  out_free
   };

   spg_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   spg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .iters     (div_iters),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   a_bad_result_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_value_ff == '0 && !rsp_last_ff))
      else $error("bad-setting result carries data");

   a_phase_in_range: assert property (@(posedge clock) disable iff (reset)
      (ctl.act == spg_pkg::ACT_MULT) |-> (!div_busy && div_rem < modulus))
      else $error("ramp phase not reduced");

   a_grad_after_div: assert property (@(posedge clock) disable iff (reset)
      (ctl.act == spg_pkg::ACT_LOAD_GRAD) |-> !div_busy)
      else $error("gradient loaded while divider busy");

endmodule
